[sv/sm3_pkg.sv]
// ----------------------------------------------------------------------------
// SM3 package
// Constants and round helper functions shared by the SM3 hash core.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [31:0] PAD_WORD = 32'h80000000;

    localparam logic [255:0] SM3_IV =
        256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

[sv/sm3_round.sv]
// ----------------------------------------------------------------------------
// SM3 round unit
// One expansion step and one compression round, shared over all 64 rounds.
// Keeps a 16-word sliding message window and the eight working words.
// ----------------------------------------------------------------------------
module sm3_round
    import sm3_pkg::*;
(
    input  logic         aclk,
    input  logic         load,      // start: take block and chain value
    input  logic         step,      // run one round
    input  logic [511:0] block,     // word 0 in top bits
    input  logic [255:0] chain,
    input  logic [5:0]   round,
    output logic [255:0] state
);

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];

    logic [31:0] w_new, a12, ss1, ss2, ff, gg, tt1, tt2, tj;

    always_comb begin
        w_new = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15))
              ^ rotl(w_reg[3], 5'd7) ^ w_reg[10];
        tj  = (round < 6'd16) ? T_LOW : T_HIGH;
        a12 = rotl(v_reg[0], 5'd12);
        ss1 = rotl(a12 + v_reg[4] + rotl(tj, round[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (round < 6'd16) begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end else begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + v_reg[7] + ss1 + w_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < 16; i++) w_reg[i] <= block[511-32*i -: 32];
            for (int i = 0; i < 8; i++)  v_reg[i] <= chain[255-32*i -: 32];
        end else if (step) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[0] <= tt1;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= rotl(v_reg[1], 5'd9);
            v_reg[3] <= v_reg[2];
            v_reg[4] <= perm0(tt2);
            v_reg[5] <= v_reg[4];
            v_reg[6] <= rotl(v_reg[5], 5'd19);
            v_reg[7] <= v_reg[6];
        end
    end

    assign state = {v_reg[0], v_reg[1], v_reg[2], v_reg[3],
                    v_reg[4], v_reg[5], v_reg[6], v_reg[7]};

endmodule

[sv/sm3_hash_core.sv]
// SM3 hash core: one compression round per cycle. A block is filled word by
// word, then loaded, run through 64 rounds and folded into the chain value.
// A non-final word leaves input open unless it fills a block; then input holds
// until that block is folded. The final word is followed by padding, 1 or 2
// compressions, then 8 digest transactions.
// Synchronous active-low reset returns the chain value to the IV.
// ----------------------------------------------------------------------------
// SM3 hash core
// Streaming SM3 digest: block fill, padding, iterative compression, output.
// ----------------------------------------------------------------------------
module sm3_hash_core
    import sm3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic        s_final_word,
    input  logic [2:0]  s_valid_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic        m_digest_end
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT
    } state_t;

    state_t         state_reg;
    logic [31:0]    buf_reg [16];
    logic [3:0]     fill_reg;
    logic [63:0]    len_reg;
    logic [255:0]   chain_reg;
    logic [5:0]     round_reg;
    logic           fin_reg;    // message closed, pad then emit
    logic           len_due_reg; // length words still to be placed
    logic           pad_due_reg; // 0x80 word still to be placed
    logic [2:0]     out_cnt_reg;
    logic [255:0]   rstate;
    logic [511:0]   block;

    logic           acc;
    logic [2:0]     vb;
    logic [31:0]    keep, word_in;

    assign acc = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign vb = (s_valid_bytes > 3'd4) ? 3'd4 : s_valid_bytes;

    always_comb begin
        case (vb)
            3'd0:    keep = 32'h00000000;
            3'd1:    keep = 32'hFF000000;
            3'd2:    keep = 32'hFFFF0000;
            3'd3:    keep = 32'hFFFFFF00;
            default: keep = 32'hFFFFFFFF;
        endcase
        word_in = s_final_word ? (s_message_word & keep) : s_message_word;
        if (s_final_word && vb != 3'd4) word_in = word_in | (PAD_WORD >> {vb, 3'b000});
    end

    always_comb begin
        for (int i = 0; i < 16; i++) block[511-32*i -: 32] = buf_reg[i];
    end

    sm3_round u_round (
        .aclk  (aclk),
        .load  (state_reg == ST_LOAD),
        .step  (state_reg == ST_ROUND),
        .block (block),
        .chain (chain_reg),
        .round (round_reg),
        .state (rstate)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            len_reg     <= '0;
            chain_reg   <= SM3_IV;
            round_reg   <= '0;
            fin_reg     <= 1'b0;
            len_due_reg <= 1'b0;
            pad_due_reg <= 1'b0;
            out_cnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        buf_reg[fill_reg] <= word_in;
                        fill_reg <= fill_reg + 4'd1;
                        if (!s_final_word) begin
                            len_reg <= len_reg + 64'd32;
                            if (fill_reg == 4'd15) state_reg <= ST_LOAD;
                        end else begin
                            len_reg     <= len_reg + {58'd0, vb, 3'b000};
                            fin_reg     <= 1'b1;
                            len_due_reg <= 1'b1;
                            // full final word: pad word still owed
                            pad_due_reg <= (vb == 3'd4);
                            state_reg   <= (fill_reg == 4'd15) ? ST_LOAD : ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    // after full final word, first slot past it takes 0x80
                    if (pad_due_reg) begin
                        buf_reg[fill_reg] <= PAD_WORD;
                        fill_reg <= fill_reg + 4'd1;
                        pad_due_reg <= 1'b0;
                        if (fill_reg == 4'd15) state_reg <= ST_LOAD;
                    end else if (fill_reg == 4'd14) begin
                        buf_reg[14] <= len_reg[63:32];
                        buf_reg[15] <= len_reg[31:0];
                        fill_reg    <= '0;
                        len_due_reg <= 1'b0;
                        state_reg   <= ST_LOAD;
                    end else begin
                        buf_reg[fill_reg] <= '0;
                        fill_reg <= fill_reg + 4'd1;
                        if (fill_reg == 4'd15) state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    round_reg <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63) state_reg <= ST_FOLD;
                end
                ST_FOLD: begin
                    chain_reg <= chain_reg ^ rstate;
                    fill_reg  <= '0;
                    if (!fin_reg) state_reg <= ST_IDLE;
                    else if (len_due_reg) state_reg <= ST_PAD;
                    else begin
                        out_cnt_reg <= '0;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        out_cnt_reg <= out_cnt_reg + 3'd1;
                        if (out_cnt_reg == 3'd7) begin
                            chain_reg <= SM3_IV;
                            len_reg   <= '0;
                            fin_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else begin
                            chain_reg <= {chain_reg[223:0], 32'd0};
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = chain_reg[255:224];
    assign m_digest_end  = (out_cnt_reg == 3'd7);

    // Result only while emitting; no input taken then.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready)) else $error("input and output both open");
    // Compression rounds run without a break until round 63.
    a_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg != 6'd63) |=> state_reg == ST_ROUND)
        else $error("round sequence broken");
    // Last digest word returns the core to idle.
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_digest_end) |=> s_ready)
        else $error("no return to idle after digest");

endmodule

[test/sm3_hash_core_tb.sv]
// ----------------------------------------------------------------------------
// SM3 hash core testbench
// Streams messages into the core, predicts each digest with a self-contained
// SM3 model and compares every digest word in order. Random idle bursts on
// both sides, quiet in the last part of the run.
// ----------------------------------------------------------------------------
module sm3_hash_core_tb;
    import sm3_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_message_word = '0;
    logic        s_final_word = 1'b0;
    logic [2:0]  s_valid_bytes = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic        m_digest_end;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } digest_beat_t;

    digest_beat_t digest_queue[$];
    logic [31:0]  hash_state[8];
    logic [31:0]  word_buf[16];
    int unsigned  word_fill;
    logic [63:0]  msg_bits;
    int unsigned  error_count = 0;
    int unsigned  words_sent = 0;
    int unsigned  digests_seen = 0;
    bit           idle_enable = 1'b1;

    always #5 aclk = ~aclk;

    sm3_hash_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_final_word   (s_final_word),
        .s_valid_bytes  (s_valid_bytes),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word  (m_digest_word),
        .m_digest_end   (m_digest_end)
    );

    function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
        n = n % 32;
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    function automatic logic [31:0] mix0(logic [31:0] x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic logic [31:0] mix1(logic [31:0] x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    task automatic hash_reset();
        for (int i = 0; i < 8; i++) hash_state[i] = SM3_IV[255 - 32*i -: 32];
        word_fill = 0;
        msg_bits  = '0;
    endtask

    task automatic compress_buffer();
        logic [31:0] w[68];
        logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++) w[j] = word_buf[j];
        for (int j = 16; j < 68; j++)
            w[j] = mix1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
        {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
        {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
            a12 = rol32(a, 12);
            ss1 = rol32(a12 + e + rol32(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end else begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rol32(b, 9); b = a; a = tt1;
            h = g; g = rol32(f, 19); f = e; e = mix0(tt2);
        end
        hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
        hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
    endtask

    task automatic buffer_word(logic [31:0] word);
        word_buf[word_fill] = word;
        word_fill++;
        if (word_fill == 16) begin
            compress_buffer();
            word_fill = 0;
        end
    endtask

    // Advance the digest model by one accepted word; queue 8 beats on final.
    task automatic predict_digest(logic [31:0] word, logic last, logic [2:0] nbytes);
        int unsigned vb;
        logic [31:0] keep;
        if (!last) begin
            buffer_word(word);
            msg_bits += 64'd32;
            return;
        end
        vb = (nbytes > 4) ? 4 : nbytes;
        msg_bits += 64'(vb * 8);
        if (vb == 4) begin
            buffer_word(word);
            buffer_word(PAD_WORD);
        end else begin
            keep = (vb == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8*vb));
            buffer_word((word & keep) | (32'h80 << (24 - 8*vb)));
        end
        while (word_fill != 14) buffer_word(32'h0);
        buffer_word(msg_bits[63:32]);
        buffer_word(msg_bits[31:0]);
        for (int k = 0; k < 8; k++) digest_queue.push_back('{hash_state[k], k == 7});
        hash_reset();
    endtask

    task automatic send_word(logic [31:0] word, logic last, logic [2:0] nbytes);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_message_word <= word;
        s_final_word   <= last;
        s_valid_bytes  <= nbytes;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_digest(word, last, nbytes);
        words_sent++;
    endtask

    // Send a message of len words with random content; last word has nbytes.
    task automatic send_message(int unsigned len, logic [2:0] nbytes);
        for (int i = 0; i < len; i++)
            send_word($urandom, i == len - 1, (i == len - 1) ? nbytes : 3'($urandom));
    endtask

    // Result side: random stall bursts, compare each beat with the oldest one.
    initial begin
        digest_beat_t want;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (digest_queue.size() == 0) begin
                    $display("%0t: unexpected digest word %h", $time, m_digest_word);
                    error_count++;
                end else begin
                    want = digest_queue.pop_front();
                    if (m_digest_word !== want.word || m_digest_end !== want.last) begin
                        $display("%0t: digest mismatch expected %h/%b actual %h/%b",
                                 $time, want.word, want.last, m_digest_word, m_digest_end);
                        error_count++;
                    end
                    if (want.last) digests_seen++;
                end
            end
            if (idle_enable && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic test_empty_and_edges();
        send_word(32'hFFFFFFFF, 1'b1, 3'd0);
        send_word(32'h61626300, 1'b1, 3'd3);
        send_word(32'hFFFFFFFF, 1'b1, 3'd4);
        send_word(32'h00000000, 1'b1, 3'd4);
        send_word(32'hFFFFFFFF, 1'b1, 3'd7);
        send_word(32'hA5A5A5A5, 1'b1, 3'd1);
        send_word(32'h5A5A5A5A, 1'b1, 3'd2);
    endtask

    task automatic test_block_boundaries();
        send_message(14, 3'd4);
        send_message(13, 3'd4);
        send_message(16, 3'd0);
    endtask

    task automatic test_random_messages();
        int unsigned len;
        while (words_sent < 200) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 18);
            send_message(len, 3'($urandom));
        end
    endtask

    task automatic test_no_idle();
        idle_enable = 1'b0;
        for (int i = 0; i < 4; i++) send_message($urandom_range(1, 20), 3'($urandom));
    endtask

    initial begin
        hash_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_edges();
        test_block_boundaries();
        test_random_messages();
        test_no_idle();
        s_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Hashed %0d words into %0d digests, with and without idle bursts.",
                 words_sent, digests_seen);
        if (error_count == 0)
            $display("sm3_hash_core_tb OK");
        else
            $display("sm3_hash_core_tb NOT OK");
        $finish;
    end

    initial begin
        #5000000;
        $display("sm3_hash_core_tb NOT OK");
        $finish;
    end

endmodule

[sm3_hash_core.f]
sv/sm3_pkg.sv
sv/sm3_round.sv
sv/sm3_hash_core.sv
test/sm3_hash_core_tb.sv
